@@ rtl/arprr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arprr_pkg
// Types and protocol constants shared by the ARP responder/resolver modules.
// ----------------------------------------------------------------------------
package arprr_pkg;

  localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
  localparam logic [15:0] HW_ETHER     = 16'h0001;
  localparam logic [15:0] PROT_IPV4    = 16'h0800;
  localparam logic [15:0] ARP_OP_REQ   = 16'h0001;
  localparam logic [15:0] ARP_OP_REP   = 16'h0002;

  localparam logic [1:0]  OUT_OP_NONE  = 2'd0;
  localparam logic [1:0]  OUT_OP_REQ   = 2'd1;
  localparam logic [1:0]  OUT_OP_REP   = 2'd2;

  localparam logic [47:0] BCAST_MAC    = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] CNT_MAX      = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RST  = 16'd2000;
  localparam logic [15:0] RETRY_RST    = 16'd250;

  typedef enum logic [1:0] {
    FUNC_PACKET  = 2'd0,
    FUNC_RESOLVE = 2'd1,
    FUNC_TICK    = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_REPLY    = 2'd0,
    KIND_REQUEST  = 2'd1,
    KIND_RESOLVED = 2'd2,
    KIND_FAILED   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_LOCAL_IP  = 2'd0,
    CFG_LOCAL_MAC = 2'd1,
    CFG_TIMEOUT   = 2'd2,
    CFG_RETRY     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [47:0] local_mac;
    logic [15:0] timeout_ms;
    logic [15:0] retry_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] frame_type;
    logic [15:0] hw_type;
    logic [15:0] prot_type;
    logic [15:0] arp_op;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [47:0] eth_dest;
    logic [1:0]  op;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
    logic [47:0] peer_mac;
  } res_t;

endpackage

@@ rtl/arprr_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arprr_regs
// Configuration register file: local addresses and resolution timing.
// ----------------------------------------------------------------------------
module arprr_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_wdata,
  output arprr_pkg::cfg_t    cfg
);

  arprr_pkg::cfg_t cfg_r;
  arprr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        arprr_pkg::CFG_LOCAL_IP:  cfg_nxt.local_ip   = cfg_wdata[31:0];
        arprr_pkg::CFG_LOCAL_MAC: cfg_nxt.local_mac  = cfg_wdata;
        arprr_pkg::CFG_TIMEOUT:   cfg_nxt.timeout_ms = cfg_wdata[15:0];
        arprr_pkg::CFG_RETRY:     cfg_nxt.retry_ms   = cfg_wdata[15:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_ip   <= '0;
      cfg_r.local_mac  <= '0;
      cfg_r.timeout_ms <= arprr_pkg::TIMEOUT_RST;
      cfg_r.retry_ms   <= arprr_pkg::RETRY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/arprr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arprr_core
// Input word register, ARP decision logic and resolver state.
// ----------------------------------------------------------------------------
module arprr_core (
  input  logic               clk,
  input  logic               rst_n,
  input  arprr_pkg::cfg_t    cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  arprr_pkg::item_t   in_item,
  output logic               res_valid,
  input  logic               res_ready,
  output arprr_pkg::res_t    res
);

  logic             s1_valid_r;
  arprr_pkg::item_t s1_item_r;

  logic [47:0] peer_r, peer_nxt;
  logic        resolving_r, resolving_nxt;
  logic [31:0] wanted_r, wanted_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [15:0] since_r, since_nxt;

  logic [15:0] elapsed_inc;
  logic [15:0] since_inc;
  logic        hit;
  logic        fire;
  arprr_pkg::res_t res_c;

  assign elapsed_inc = (elapsed_r == arprr_pkg::CNT_MAX) ? elapsed_r : elapsed_r + 16'd1;
  assign since_inc   = (since_r == arprr_pkg::CNT_MAX) ? since_r : since_r + 16'd1;

  always_comb begin
    peer_nxt      = peer_r;
    resolving_nxt = resolving_r;
    wanted_nxt    = wanted_r;
    elapsed_nxt   = elapsed_r;
    since_nxt     = since_r;
    hit           = 1'b0;
    res_c         = '0;
    case (s1_item_r.func)
      arprr_pkg::FUNC_PACKET: begin
        if (!resolving_r) begin
          if (s1_item_r.frame_type == arprr_pkg::ETH_TYPE_ARP &&
              s1_item_r.hw_type == arprr_pkg::HW_ETHER &&
              s1_item_r.prot_type == arprr_pkg::PROT_IPV4 &&
              s1_item_r.arp_op == arprr_pkg::ARP_OP_REQ &&
              s1_item_r.target_ip == cfg.local_ip) begin
            hit              = 1'b1;
            peer_nxt         = s1_item_r.sender_mac;
            res_c.kind       = arprr_pkg::KIND_REPLY;
            res_c.eth_dest   = s1_item_r.sender_mac;
            res_c.op         = arprr_pkg::OUT_OP_REP;
            res_c.sender_mac = cfg.local_mac;
            res_c.sender_ip  = cfg.local_ip;
            res_c.target_mac = s1_item_r.sender_mac;
            res_c.target_ip  = s1_item_r.sender_ip;
          end
        end else if (s1_item_r.frame_type == arprr_pkg::ETH_TYPE_ARP &&
                     s1_item_r.prot_type == arprr_pkg::PROT_IPV4 &&
                     s1_item_r.arp_op == arprr_pkg::ARP_OP_REP &&
                     s1_item_r.sender_ip == wanted_r) begin
          hit           = 1'b1;
          peer_nxt      = s1_item_r.sender_mac;
          resolving_nxt = 1'b0;
          res_c.kind    = arprr_pkg::KIND_RESOLVED;
        end
      end
      arprr_pkg::FUNC_RESOLVE: begin
        if (!resolving_r) begin
          hit              = 1'b1;
          resolving_nxt    = 1'b1;
          wanted_nxt       = s1_item_r.query_ip;
          elapsed_nxt      = '0;
          since_nxt        = '0;
          res_c.kind       = arprr_pkg::KIND_REQUEST;
          res_c.eth_dest   = arprr_pkg::BCAST_MAC;
          res_c.op         = arprr_pkg::OUT_OP_REQ;
          res_c.sender_mac = cfg.local_mac;
          res_c.sender_ip  = cfg.local_ip;
          res_c.target_ip  = s1_item_r.query_ip;
        end
      end
      arprr_pkg::FUNC_TICK: begin
        if (resolving_r) begin
          elapsed_nxt = elapsed_inc;
          since_nxt   = since_inc;
          if (elapsed_inc >= cfg.timeout_ms) begin
            hit           = 1'b1;
            resolving_nxt = 1'b0;
            peer_nxt      = arprr_pkg::BCAST_MAC;
            res_c.kind    = arprr_pkg::KIND_FAILED;
          end else if (since_inc >= cfg.retry_ms) begin
            hit              = 1'b1;
            since_nxt        = '0;
            res_c.kind       = arprr_pkg::KIND_REQUEST;
            res_c.eth_dest   = arprr_pkg::BCAST_MAC;
            res_c.op         = arprr_pkg::OUT_OP_REQ;
            res_c.sender_mac = cfg.local_mac;
            res_c.sender_ip  = cfg.local_ip;
            res_c.target_ip  = wanted_r;
          end
        end
      end
      default: hit = 1'b0;
    endcase
    res_c.peer_mac = peer_nxt;
  end

  // advance the held word unless its result is blocked downstream
  assign fire      = s1_valid_r && (!hit || res_ready);
  assign in_ready  = !s1_valid_r || fire;
  assign res_valid = s1_valid_r && hit;
  assign res       = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      peer_r      <= '0;
      resolving_r <= 1'b0;
      wanted_r    <= '0;
      elapsed_r   <= '0;
      since_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (fire) begin
        peer_r      <= peer_nxt;
        resolving_r <= resolving_nxt;
        wanted_r    <= wanted_nxt;
        elapsed_r   <= elapsed_nxt;
        since_r     <= since_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

endmodule

@@ rtl/arprr_skid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arprr_skid
// Output register with a skid stage so the ready path stays registered.
// ----------------------------------------------------------------------------
module arprr_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s_valid,
  output logic               s_ready,
  input  arprr_pkg::res_t    s_data,
  output logic               m_valid,
  input  logic               m_ready,
  output arprr_pkg::res_t    m_data
);

  logic            out_valid_r;
  arprr_pkg::res_t out_data_r;
  logic            skid_valid_r;
  arprr_pkg::res_t skid_data_r;
  logic            push;

  assign s_ready = !skid_valid_r;
  assign push    = s_valid && s_ready;
  assign m_valid = out_valid_r;
  assign m_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || m_ready) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || m_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : s_data;
    end else if (push) begin
      skid_data_r <= s_data;
    end
  end

endmodule

@@ rtl/arp_responder_resolver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_responder_resolver
// ARP responder and single-address resolver for Ethernet/IPv4.
// ----------------------------------------------------------------------------
// Takes one input word per clock unless a word with a result is held back by a
// full skid stage. Each word is a received ARP packet, a resolve request or a
// 1 ms tick (in_tuser). The word is registered in the input word register,
// decided against the resolver state and its result, if any, lands in an
// output register backed by a skid stage, so input keeps flowing while a result waits.
// Throughput is one word per cycle unless output back-pressure stalls the
// single decision stage that updates the resolver state. After reset the timeout
// is 2000 ms and the retry interval 250 ms; write configuration only while idle.
// ----------------------------------------------------------------------------
module arp_responder_resolver (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // frame_type, hw_type, prot_type, arp_op, sender_mac, sender_ip,
  // target_ip, query_ip
  input  logic [207:0] in_tdata,
  // func
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // eth_dest, out_op, out_sender_mac, out_sender_ip, out_target_mac,
  // out_target_ip, peer_mac, zero fill
  output logic [263:0] out_tdata,
  // kind
  output logic [1:0]   out_tuser
);

  arprr_pkg::cfg_t  cfg;
  arprr_pkg::item_t item;
  arprr_pkg::res_t  res;
  arprr_pkg::res_t  out_res;
  logic             res_valid;
  logic             res_ready;

  assign item.func       = in_tuser;
  assign item.frame_type = in_tdata[15:0];
  assign item.hw_type    = in_tdata[31:16];
  assign item.prot_type  = in_tdata[47:32];
  assign item.arp_op     = in_tdata[63:48];
  assign item.sender_mac = in_tdata[111:64];
  assign item.sender_ip  = in_tdata[143:112];
  assign item.target_ip  = in_tdata[175:144];
  assign item.query_ip   = in_tdata[207:176];

  arprr_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  arprr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  arprr_skid u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (res_valid),
    .s_ready (res_ready),
    .s_data  (res),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (out_res)
  );

  assign out_tuser           = out_res.kind;
  assign out_tdata[47:0]     = out_res.eth_dest;
  assign out_tdata[49:48]    = out_res.op;
  assign out_tdata[97:50]    = out_res.sender_mac;
  assign out_tdata[129:98]   = out_res.sender_ip;
  assign out_tdata[177:130]  = out_res.target_mac;
  assign out_tdata[209:178]  = out_res.target_ip;
  assign out_tdata[257:210]  = out_res.peer_mac;
  assign out_tdata[263:258]  = 6'd0;

endmodule

@@ rtl/arprr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arprr_checker
// Port-level checks for the ARP responder/resolver, bound to the top level.
// ----------------------------------------------------------------------------
module arprr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         cfg_we,
  input logic [1:0]   cfg_index,
  input logic [47:0]  cfg_wdata,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [207:0] in_tdata,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [263:0] out_tdata,
  input logic [1:0]   out_tuser
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word present right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed or dropped");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == arprr_pkg::KIND_RESOLVED ||
                   out_tuser == arprr_pkg::KIND_FAILED) |-> out_tdata[209:0] == '0)
    else $error("status word carries frame fields");

  a_fail_bcast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == arprr_pkg::KIND_FAILED |->
      out_tdata[257:210] == arprr_pkg::BCAST_MAC)
    else $error("failed resolution without broadcast peer");

  a_request_bcast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == arprr_pkg::KIND_REQUEST |->
      out_tdata[47:0] == arprr_pkg::BCAST_MAC && out_tdata[49:48] == arprr_pkg::OUT_OP_REQ)
    else $error("request word not broadcast");

endmodule

bind arp_responder_resolver arprr_checker u_arprr_checker (.*);
